[rtl/n2a_pkg.sv]
// ----------------------------------------------------------------------------
// n2a_pkg
// Shared types and constants for the number to ascii formatter.
// ----------------------------------------------------------------------------
package n2a_pkg;

   localparam int FUNC_W      = 2;
   localparam int VALUE_W     = 32;
   localparam int CHAR_W      = 8;
   localparam int DIGIT_W     = 4;
   localparam int DEC_DIGITS  = 10;
   localparam int DIGITS_BITS = DEC_DIGITS * DIGIT_W;
   localparam int NDIG_W      = $clog2(DEC_DIGITS + 1);

   localparam int QUEUE_DEPTH_DEF = 2;

   localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_X    = 8'h78;
   localparam logic [CHAR_W-1:0] CHAR_A    = 8'h41;
   localparam logic [CHAR_W-1:0] DEC_BASE  = 8'd10;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_DEC32 = 2'd0,
      FUNC_HEX8  = 2'd1,
      FUNC_HEX16 = 2'd2,
      FUNC_HEX32 = 2'd3
   } func_type;

   // one formatting job: digits least significant first, ndig of them are written
   typedef struct packed {
      logic                                hex;
      logic [NDIG_W-1:0]                   ndig;
      logic [DEC_DIGITS-1:0][DIGIT_W-1:0] digits;
   } entry_type;

endpackage

[rtl/n2a_req_if.sv]
// ----------------------------------------------------------------------------
// n2a_req_if
// Request channel: format code and value, valid/ready handshake.
// ----------------------------------------------------------------------------
interface n2a_req_if;
   import n2a_pkg::*;

   logic               valid;
   logic               ready;
   logic [FUNC_W-1:0]  func;
   logic [VALUE_W-1:0] value;

   modport source (output valid, output func, output value, input ready);
   modport sink (input valid, input func, input value, output ready);
endinterface

[rtl/n2a_rsp_if.sv]
// ----------------------------------------------------------------------------
// n2a_rsp_if
// Response channel: one ascii character per transfer, last flags the end.
// ----------------------------------------------------------------------------
interface n2a_rsp_if;
   import n2a_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] character;
   logic              last;

   modport source (output valid, output character, output last, input ready);
   modport sink (input valid, input character, input last, output ready);
endinterface

[rtl/number_to_ascii_formatter_core.sv]
// ----------------------------------------------------------------------------
// number_to_ascii_formatter_core
// Formats an unsigned value as decimal or 0x-prefixed upper-case hex text.
// ----------------------------------------------------------------------------
// req_ch carries func (0 decimal, 1 hex8, 2 hex16, 3 hex32) and a 32-bit
// value; rsp_ch returns the text one ascii character per transfer, with
// last high on the final character. Decimal text has no leading zeros,
// hex text is "0x" and 2, 4 or 8 digits.
// The front part holds one request at a time: a hex request goes straight
// to its job, a decimal request first runs shift-and-add-3 bcd conversion
// over the value bits, and each then hands its job to the queue.
// The back part sends one character per cycle from the queue head while
// the receiver is ready, and picks up each new job before its first
// character. The queue lets the front take a new request while the back
// still sends earlier text; the pace is set by the bcd conversion loop
// for decimal values and by the character count for hex values.
// A stalled receiver holds the response register; the queue then fills
// and the front stops taking requests.
// Reset clears the controller state and the queue; no clearing pass.
// ----------------------------------------------------------------------------
module number_to_ascii_formatter_core #(
   parameter int QUEUE_DEPTH = n2a_pkg::QUEUE_DEPTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   n2a_req_if.sink   req_ch,
   n2a_rsp_if.source rsp_ch
);
   import n2a_pkg::*;

   logic      push_valid, push_ready;
   entry_type push_entry;
   logic      pop_valid, pop_ready;
   entry_type pop_entry;

   n2a_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   n2a_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   n2a_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_entry (pop_entry),
      .rsp_ch    (rsp_ch)
   );

endmodule

[rtl/n2a_front.sv]
// ----------------------------------------------------------------------------
// n2a_front
// Accepts requests, turns decimal values into bcd by shift-and-add-3 and
// builds a digit job for the queue.
// ----------------------------------------------------------------------------
module n2a_front (
   input  logic              clock,
   input  logic              reset,
   n2a_req_if.sink           req_ch,
   output logic              push_valid,
   input  logic              push_ready,
   output n2a_pkg::entry_type push_entry
);
   import n2a_pkg::*;

   localparam int CNT_W = $clog2(VALUE_W);

   typedef enum logic [2:0] {
      ST_IDLE    = 3'b001,
      ST_CONVERT = 3'b010,
      ST_PUSH    = 3'b100
   } state_type;

   state_type                          state_ff, state_in;
   logic [VALUE_W-1:0]                 bin_ff, bin_in;
   logic [DEC_DIGITS-1:0][DIGIT_W-1:0] bcd_ff, bcd_in;
   logic [CNT_W-1:0]                   bit_cnt_ff, bit_cnt_in;
   entry_type                          entry_ff, entry_in;

   function automatic logic [DEC_DIGITS-1:0][DIGIT_W-1:0] dabble_adjust(
      input logic [DEC_DIGITS-1:0][DIGIT_W-1:0] bcd);
      logic [DEC_DIGITS-1:0][DIGIT_W-1:0] res;
      for (int i = 0; i < DEC_DIGITS; i++) begin
         res[i] = (bcd[i] >= DIGIT_W'(5)) ? bcd[i] + DIGIT_W'(3) : bcd[i];
      end
      return res;
   endfunction

   // significant digit count, at least one so that zero gives "0"
   function automatic logic [NDIG_W-1:0] count_digits(
      input logic [DEC_DIGITS-1:0][DIGIT_W-1:0] bcd);
      logic [NDIG_W-1:0] n;
      n = NDIG_W'(1);
      for (int i = 1; i < DEC_DIGITS; i++) begin
         if (bcd[i] != '0) n = NDIG_W'(i + 1);
      end
      return n;
   endfunction

   always_comb begin
      state_in   = state_ff;
      bin_in     = bin_ff;
      bcd_in     = bcd_ff;
      bit_cnt_in = bit_cnt_ff;
      entry_in   = entry_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               case (func_type'(req_ch.func))
                  FUNC_DEC32: begin
                     bin_in     = req_ch.value;
                     bcd_in     = '0;
                     bit_cnt_in = '0;
                     state_in   = ST_CONVERT;
                  end
                  FUNC_HEX8: begin
                     entry_in.hex    = 1'b1;
                     entry_in.ndig   = NDIG_W'(2);
                     entry_in.digits = DIGITS_BITS'(req_ch.value[7:0]);
                     state_in        = ST_PUSH;
                  end
                  FUNC_HEX16: begin
                     entry_in.hex    = 1'b1;
                     entry_in.ndig   = NDIG_W'(4);
                     entry_in.digits = DIGITS_BITS'(req_ch.value[15:0]);
                     state_in        = ST_PUSH;
                  end
                  FUNC_HEX32: begin
                     entry_in.hex    = 1'b1;
                     entry_in.ndig   = NDIG_W'(8);
                     entry_in.digits = DIGITS_BITS'(req_ch.value);
                     state_in        = ST_PUSH;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_CONVERT: begin
            bcd_in     = {DIGITS_BITS'(dabble_adjust(bcd_ff)) << 1} | DIGITS_BITS'(bin_ff[VALUE_W-1]);
            bin_in     = {bin_ff[VALUE_W-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff + CNT_W'(1);
            if (bit_cnt_ff == CNT_W'(VALUE_W - 1)) begin
               entry_in.hex    = 1'b0;
               entry_in.digits = bcd_in;
               entry_in.ndig   = count_digits(bcd_in);
               state_in        = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (push_ready) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      bin_ff     <= bin_in;
      bcd_ff     <= bcd_in;
      bit_cnt_ff <= bit_cnt_in;
      entry_ff   <= entry_in;
   end

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign push_valid   = (state_ff == ST_PUSH);
   assign push_entry   = entry_ff;

   a_dec_ndig_range: assert property (@(posedge clock) disable iff (reset)
      (push_valid && !entry_ff.hex) |->
         (entry_ff.ndig >= NDIG_W'(1) && entry_ff.ndig <= NDIG_W'(DEC_DIGITS)))
      else $error("decimal job with bad digit count");

   a_convert_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONVERT && bit_cnt_ff == CNT_W'(VALUE_W - 1)) |=> (state_ff == ST_PUSH))
      else $error("conversion did not finish after the last shift");

endmodule

[rtl/n2a_queue.sv]
// ----------------------------------------------------------------------------
// n2a_queue
// Small fifo of digit jobs between the front and back parts.
// ----------------------------------------------------------------------------
module n2a_queue #(
   parameter int DEPTH = n2a_pkg::QUEUE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  n2a_pkg::entry_type push_entry,
   output logic               pop_valid,
   input  logic               pop_ready,
   output n2a_pkg::entry_type pop_entry
);
   import n2a_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_entry  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) count_in = count_ff + CNT_W'(1);
      if (do_pop && !do_push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) mem_ff[wr_ptr_ff] <= push_entry;
   end

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (rd_ptr_ff == wr_ptr_ff))
      else $error("queue empty but pointers differ");

endmodule

[rtl/n2a_back.sv]
// ----------------------------------------------------------------------------
// n2a_back
// Walks one digit job and sends its characters, prefix first, through a
// registered response stage.
// ----------------------------------------------------------------------------
module n2a_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  n2a_pkg::entry_type pop_entry,
   n2a_rsp_if.source          rsp_ch
);
   import n2a_pkg::*;

   localparam int IDX_W = $clog2(DEC_DIGITS);

   logic                               busy_ff, busy_in;
   logic [1:0]                         pfx_ff, pfx_in;
   logic [NDIG_W-1:0]                  rem_ff, rem_in;
   logic [DEC_DIGITS-1:0][DIGIT_W-1:0] digits_ff, digits_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]                  char_ff, char_in;
   logic                               last_ff, last_in;
   logic                               out_free;
   logic [IDX_W-1:0]                   digit_idx;
   logic [DIGIT_W-1:0]                 cur_nib;

   function automatic logic [CHAR_W-1:0] to_ascii(input logic [DIGIT_W-1:0] nib);
      logic [CHAR_W-1:0] wide;
      wide = CHAR_W'(nib);
      return (wide < DEC_BASE) ? wide + CHAR_ZERO : wide - DEC_BASE + CHAR_A;
   endfunction

   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign pop_ready = !busy_ff;
   assign digit_idx = IDX_W'(rem_ff - NDIG_W'(1));
   assign cur_nib   = digits_ff[digit_idx];

   always_comb begin
      busy_in      = busy_ff;
      pfx_in       = pfx_ff;
      rem_in       = rem_ff;
      digits_in    = digits_ff;
      rsp_valid_in = rsp_valid_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      if (out_free) rsp_valid_in = 1'b0;
      if (busy_ff && out_free) begin
         rsp_valid_in = 1'b1;
         if (pfx_ff != 2'd0) begin
            char_in = (pfx_ff == 2'd2) ? CHAR_ZERO : CHAR_X;
            last_in = 1'b0;
            pfx_in  = pfx_ff - 2'd1;
         end else begin
            char_in = to_ascii(cur_nib);
            last_in = (rem_ff == NDIG_W'(1));
            rem_in  = rem_ff - NDIG_W'(1);
            if (rem_ff == NDIG_W'(1)) busy_in = 1'b0;
         end
      end
      if (!busy_ff && pop_valid) begin
         busy_in   = 1'b1;
         pfx_in    = pop_entry.hex ? 2'd2 : 2'd0;
         rem_in    = pop_entry.ndig;
         digits_in = pop_entry.digits;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pfx_ff    <= pfx_in;
      rem_ff    <= rem_in;
      digits_ff <= digits_in;
      char_ff   <= char_in;
      last_ff   <= last_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.character = char_ff;
   assign rsp_ch.last      = last_ff;

   a_busy_has_digits: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (rem_ff != '0))
      else $error("job active with no digits left");

   a_last_ends_job: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && out_free && pfx_ff == 2'd0 && rem_ff == NDIG_W'(1)) |=>
         (!busy_ff && rsp_ch.valid && rsp_ch.last))
      else $error("final digit did not close the job");

endmodule
